// File: sv/dop_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option parser package
// Shared types and option codes for the DHCP option parser.
// ----------------------------------------------------------------------------
package dop_pkg;

    localparam int unsigned AddrW  = 32;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 3;

    localparam logic [ByteW-1:0] OPT_PAD    = 8'd0;
    localparam logic [ByteW-1:0] OPT_MASK   = 8'd1;
    localparam logic [ByteW-1:0] OPT_ROUTER = 8'd3;
    localparam logic [ByteW-1:0] OPT_DNS    = 8'd6;
    localparam logic [ByteW-1:0] OPT_TYPE   = 8'd53;
    localparam logic [ByteW-1:0] OPT_END    = 8'd255;

    localparam logic [ByteW-1:0] TYPE_OFFER = 8'd2;
    localparam logic [ByteW-1:0] TYPE_ACK   = 8'd5;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic REASON_END = 1'b0;
    localparam logic REASON_ACK = 1'b1;

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2
    } t_phase;

    typedef struct packed {
        logic             cmd;
        logic [ByteW-1:0] data_byte;
        logic [AddrW-1:0] offered_addr;
    } t_item;

    typedef struct packed {
        logic             send_request;
        logic             got_address;
        logic [AddrW-1:0] assigned_addr;
        logic [AddrW-1:0] router_addr;
        logic [AddrW-1:0] dns_addr;
        logic [AddrW-1:0] subnet_mask;
        logic             end_reason;
    } t_result;

endpackage

// File: sv/dop_in_reg.sv
// ----------------------------------------------------------------------------
// DHCP option parser input register
// Holds one accepted input transfer until the option walker consumes it.
// ----------------------------------------------------------------------------
module dop_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  dop_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output dop_pkg::t_item o_item
);

    logic           r_valid;
    dop_pkg::t_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/dop_walker.sv
// ----------------------------------------------------------------------------
// DHCP option walker
// Walks code, length and value fields one byte per cycle while its input fires
// and keeps the captured options, the offered address and the committed address.
// ----------------------------------------------------------------------------
module dop_walker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  dop_pkg::t_item   i_item,
    output logic             o_emit,
    output dop_pkg::t_result o_result
);

    dop_pkg::t_phase                  r_phase, n_phase;
    logic [dop_pkg::ByteW-1:0]        r_code, n_code;
    logic [dop_pkg::ByteW-1:0]        r_left, n_left;
    logic [dop_pkg::AddrW-1:0]        r_accum, n_accum;
    logic [dop_pkg::CountW-1:0]       r_count, n_count;
    logic [dop_pkg::AddrW-1:0]        r_offer, n_offer;
    logic                             r_offer_seen, n_offer_seen;
    logic                             r_addr_valid, n_addr_valid;
    logic [dop_pkg::AddrW-1:0]        r_client, n_client;
    logic [dop_pkg::AddrW-1:0]        r_router, n_router;
    logic [dop_pkg::AddrW-1:0]        r_dns, n_dns;
    logic [dop_pkg::AddrW-1:0]        r_mask, n_mask;
    logic                             r_done, n_done;

    logic                             byte_live;
    logic                             finish;
    logic                             emit_end;
    logic [dop_pkg::ByteW-1:0]        left_dec;
    logic [dop_pkg::AddrW-1:0]        acc_step;
    logic [dop_pkg::CountW-1:0]       cnt_step;
    logic [dop_pkg::AddrW-1:0]        value;
    logic [dop_pkg::ByteW-1:0]        msg_type;

    assign byte_live = i_fire && (i_item.cmd == dop_pkg::CMD_BYTE) && !r_done;
    assign left_dec  = r_left - dop_pkg::ByteW'(1);

    always_comb begin
        acc_step = r_accum;
        cnt_step = r_count;
        if (r_count < dop_pkg::CountW'(4)) begin
            acc_step = {r_accum[dop_pkg::AddrW-dop_pkg::ByteW-1:0], i_item.data_byte};
            cnt_step = r_count + dop_pkg::CountW'(1);
        end
    end

    always_comb begin
        finish   = 1'b0;
        emit_end = 1'b0;
        n_accum  = r_accum;
        n_count  = r_count;
        n_left   = r_left;
        n_code   = r_code;
        if (byte_live) begin
            unique case (r_phase)
                dop_pkg::PH_LEN: begin
                    n_left  = i_item.data_byte;
                    n_accum = '0;
                    n_count = '0;
                    finish  = (i_item.data_byte == '0);
                end
                dop_pkg::PH_VAL: begin
                    n_accum = acc_step;
                    n_count = cnt_step;
                    n_left  = left_dec;
                    finish  = (left_dec == '0);
                end
                default: begin
                    if (i_item.data_byte == dop_pkg::OPT_END) begin
                        emit_end = 1'b1;
                    end else if (i_item.data_byte != dop_pkg::OPT_PAD) begin
                        n_code = i_item.data_byte;
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (n_count)
            3'd0:    value = '0;
            3'd1:    value = {n_accum[7:0], 24'd0};
            3'd2:    value = {n_accum[15:0], 16'd0};
            3'd3:    value = {n_accum[23:0], 8'd0};
            default: value = n_accum;
        endcase
    end

    assign msg_type = value[dop_pkg::AddrW-1 -: dop_pkg::ByteW];

    always_comb begin
        n_phase = r_phase;
        if (i_fire && (i_item.cmd == dop_pkg::CMD_START)) begin
            n_phase = dop_pkg::PH_CODE;
        end else if (byte_live) begin
            unique case (r_phase)
                dop_pkg::PH_LEN: begin
                    n_phase = finish ? dop_pkg::PH_CODE : dop_pkg::PH_VAL;
                end
                dop_pkg::PH_VAL: begin
                    n_phase = finish ? dop_pkg::PH_CODE : dop_pkg::PH_VAL;
                end
                default: begin
                    if ((i_item.data_byte == dop_pkg::OPT_END) ||
                        (i_item.data_byte == dop_pkg::OPT_PAD)) begin
                        n_phase = dop_pkg::PH_CODE;
                    end else begin
                        n_phase = dop_pkg::PH_LEN;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_offer      = r_offer;
        n_offer_seen = r_offer_seen;
        n_addr_valid = r_addr_valid;
        n_client     = r_client;
        n_router     = r_router;
        n_dns        = r_dns;
        n_mask       = r_mask;
        n_done       = r_done;
        o_emit       = 1'b0;
        o_result.end_reason = dop_pkg::REASON_END;
        if (i_fire && (i_item.cmd == dop_pkg::CMD_START)) begin
            n_offer      = i_item.offered_addr;
            n_offer_seen = 1'b0;
            n_done       = 1'b0;
        end else if (emit_end) begin
            o_emit = 1'b1;
            n_done = 1'b1;
        end else if (finish) begin
            case (r_code)
                dop_pkg::OPT_ROUTER: n_router = value;
                dop_pkg::OPT_DNS:    n_dns    = value;
                dop_pkg::OPT_MASK:   n_mask   = value;
                dop_pkg::OPT_TYPE: begin
                    if (msg_type == dop_pkg::TYPE_OFFER) begin
                        n_offer_seen = 1'b1;
                    end else if (msg_type == dop_pkg::TYPE_ACK) begin
                        n_offer_seen        = 1'b0;
                        n_addr_valid        = 1'b1;
                        n_client            = r_offer;
                        n_done              = 1'b1;
                        o_emit              = 1'b1;
                        o_result.end_reason = dop_pkg::REASON_ACK;
                    end
                end
                default: ;
            endcase
        end
        o_result.send_request  = n_offer_seen;
        o_result.got_address   = n_addr_valid;
        o_result.assigned_addr = n_client;
        o_result.router_addr   = n_router;
        o_result.dns_addr      = n_dns;
        o_result.subnet_mask   = n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dop_pkg::PH_CODE;
            r_code       <= '0;
            r_left       <= '0;
            r_accum      <= '0;
            r_count      <= '0;
            r_offer      <= '0;
            r_offer_seen <= 1'b0;
            r_addr_valid <= 1'b0;
            r_client     <= '0;
            r_router     <= '0;
            r_dns        <= '0;
            r_mask       <= '0;
            r_done       <= 1'b1;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_offer      <= n_offer;
            r_offer_seen <= n_offer_seen;
            r_addr_valid <= n_addr_valid;
            r_client     <= n_client;
            r_router     <= n_router;
            r_dns        <= n_dns;
            r_mask       <= n_mask;
            r_done       <= n_done;
            if (i_item.cmd == dop_pkg::CMD_START) begin
                r_code  <= '0;
                r_left  <= '0;
                r_accum <= '0;
                r_count <= '0;
            end else begin
                r_code  <= n_code;
                r_left  <= n_left;
                r_accum <= n_accum;
                r_count <= n_count;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.cmd == dop_pkg::CMD_BYTE) && r_done) |-> !o_emit)
        else $error("result emitted while no packet was open");

    a_ack_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && (o_result.end_reason == dop_pkg::REASON_ACK)) |->
        (o_result.got_address && !o_result.send_request))
        else $error("acknowledge result without committed address");

    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.cmd == dop_pkg::CMD_START)) |=>
        (!r_done && (r_phase == dop_pkg::PH_CODE) && (r_count == '0)))
        else $error("start transfer did not open a packet");

    a_addr_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr_valid |=> r_addr_valid)
        else $error("got-address flag dropped");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_done)
        else $error("packet still open after its result");
`endif

endmodule

// File: sv/dop_out_reg.sv
// ----------------------------------------------------------------------------
// DHCP option parser result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module dop_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dop_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output dop_pkg::t_result o_result
);

    logic             r_valid;
    dop_pkg::t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: sv/dhcp_option_parser.sv
// ----------------------------------------------------------------------------
// DHCP option parser
// A start transfer loads the offered address; each byte transfer after it
// advances the option walk by one byte. One byte is taken every clock
// cycle unless the result register is full and stalled. A transfer passes
// through an input register and the option walker, and the result for the
// byte that closes the packet (END option or ACK message type) is loaded
// into the result register. The walker holds its input while the result
// register is full and stalled, so throughput then follows the downstream side.
// ----------------------------------------------------------------------------
module dhcp_option_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_offered_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_send_request,
    output logic        o_got_address,
    output logic [31:0] o_assigned_addr,
    output logic [31:0] o_router_addr,
    output logic [31:0] o_dns_addr,
    output logic [31:0] o_subnet_mask,
    output logic        o_end_reason
);

    dop_pkg::t_item   in_item;
    dop_pkg::t_item   held_item;
    dop_pkg::t_result walk_result;
    dop_pkg::t_result out_result;
    logic             held_valid;
    logic             out_ready;
    logic             fire;
    logic             emit;

    assign in_item.cmd          = i_cmd;
    assign in_item.data_byte    = i_data_byte;
    assign in_item.offered_addr = i_offered_addr;

    assign fire = held_valid && out_ready;

    dop_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_take  (out_ready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    dop_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (walk_result)
    );

    dop_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && emit),
        .i_result (walk_result),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_send_request  = out_result.send_request;
    assign o_got_address   = out_result.got_address;
    assign o_assigned_addr = out_result.assigned_addr;
    assign o_router_addr   = out_result.router_addr;
    assign o_dns_addr      = out_result.dns_addr;
    assign o_subnet_mask   = out_result.subnet_mask;
    assign o_end_reason    = out_result.end_reason;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DHCP option parser testbench
// Streams start and option-byte transfers into the parser under random
// idling on both sides. A local option walker predicts every closing result
// (END or ACK), and each received result is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int CycleLimit = 200000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_cmd          = dop_pkg::CMD_START;
    logic [7:0]  i_data_byte    = '0;
    logic [31:0] i_offered_addr = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_send_request;
    logic        o_got_address;
    logic [31:0] o_assigned_addr;
    logic [31:0] o_router_addr;
    logic [31:0] o_dns_addr;
    logic [31:0] o_subnet_mask;
    logic        o_end_reason;

    dhcp_option_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_offered_addr (i_offered_addr),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_send_request (o_send_request),
        .o_got_address  (o_got_address),
        .o_assigned_addr(o_assigned_addr),
        .o_router_addr  (o_router_addr),
        .o_dns_addr     (o_dns_addr),
        .o_subnet_mask  (o_subnet_mask),
        .o_end_reason   (o_end_reason)
    );

    always #4 i_clk = ~i_clk;

    dop_pkg::t_item   option_stream[$];
    dop_pkg::t_result expected_leases[$];
    int      mismatches  = 0;
    int      taken_count = 0;
    int      cycles      = 0;
    int      fed_count   = 0;
    logic    gen_open    = 1'b0;

    // Walker state, mirrors the parser after reset.
    dop_pkg::t_phase walk_phase = dop_pkg::PH_CODE;
    logic [7:0]  opt_code      = '0;
    logic [7:0]  bytes_left    = '0;
    logic [31:0] opt_value     = '0;
    logic [2:0]  opt_count     = '0;
    logic [31:0] held_offer    = '0;
    logic        offer_flag    = 1'b0;
    logic        bound_flag    = 1'b0;
    logic [31:0] lease_addr    = '0;
    logic [31:0] router_value  = '0;
    logic [31:0] dns_value     = '0;
    logic [31:0] mask_value    = '0;
    logic        packet_closed = 1'b1;

    function automatic logic calm_window();
        return taken_count >= 250 && taken_count < 400;
    endfunction

    task automatic post_lease(input logic why);
        dop_pkg::t_result r;
        r.send_request  = offer_flag;
        r.got_address   = bound_flag;
        r.assigned_addr = lease_addr;
        r.router_addr   = router_value;
        r.dns_addr      = dns_value;
        r.subnet_mask   = mask_value;
        r.end_reason    = why;
        expected_leases.push_back(r);
        packet_closed = 1'b1;
    endtask

    task automatic close_option();
        logic [31:0] v;
        v = opt_value << (8 * (4 - opt_count));
        walk_phase = dop_pkg::PH_CODE;
        case (opt_code)
            dop_pkg::OPT_ROUTER: router_value = v;
            dop_pkg::OPT_DNS:    dns_value = v;
            dop_pkg::OPT_MASK:   mask_value = v;
            dop_pkg::OPT_TYPE: begin
                if (v[31:24] == dop_pkg::TYPE_OFFER) begin
                    offer_flag = 1'b1;
                end else if (v[31:24] == dop_pkg::TYPE_ACK) begin
                    offer_flag = 1'b0;
                    bound_flag = 1'b1;
                    lease_addr = held_offer;
                    post_lease(dop_pkg::REASON_ACK);
                end
            end
            default: ;
        endcase
    endtask

    task automatic advance_walker(input logic cmd, input logic [7:0] b,
                                  input logic [31:0] addr);
        if (cmd == dop_pkg::CMD_START) begin
            held_offer    = addr;
            offer_flag    = 1'b0;
            packet_closed = 1'b0;
            walk_phase    = dop_pkg::PH_CODE;
            opt_code      = '0;
            bytes_left    = '0;
            opt_value     = '0;
            opt_count     = '0;
        end else if (!packet_closed) begin
            case (walk_phase)
                dop_pkg::PH_LEN: begin
                    bytes_left = b;
                    opt_value  = '0;
                    opt_count  = '0;
                    if (b == 8'd0) begin
                        close_option();
                    end else begin
                        walk_phase = dop_pkg::PH_VAL;
                    end
                end
                dop_pkg::PH_VAL: begin
                    if (opt_count < 3'd4) begin
                        opt_value = {opt_value[23:0], b};
                        opt_count = opt_count + 3'd1;
                    end
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0) begin
                        close_option();
                    end
                end
                default: begin
                    walk_phase = dop_pkg::PH_CODE;
                    if (b == dop_pkg::OPT_END) begin
                        post_lease(dop_pkg::REASON_END);
                    end else if (b != dop_pkg::OPT_PAD) begin
                        opt_code   = b;
                        walk_phase = dop_pkg::PH_LEN;
                    end
                end
            endcase
        end
    endtask

    function automatic string lease_text(input dop_pkg::t_result r);
        return $sformatf("req=%0d got=%0d addr=%h rtr=%h dns=%h mask=%h why=%0d",
                         r.send_request, r.got_address, r.assigned_addr,
                         r.router_addr, r.dns_addr, r.subnet_mask, r.end_reason);
    endfunction

    always @(posedge i_clk) begin : drive_proc
        dop_pkg::t_item nxt;
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                advance_walker(i_cmd, i_data_byte, i_offered_addr);
                taken_count = taken_count + 1;
            end
            if (!i_valid || !o_stall) begin
                if (option_stream.size() != 0 &&
                    (calm_window() || $urandom_range(99) >= 12)) begin
                    nxt = option_stream.pop_front();
                    i_valid        <= 1'b1;
                    i_cmd          <= nxt.cmd;
                    i_data_byte    <= nxt.data_byte;
                    i_offered_addr <= nxt.offered_addr;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_proc
        dop_pkg::t_result got;
        dop_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.send_request  = o_send_request;
                got.got_address   = o_got_address;
                got.assigned_addr = o_assigned_addr;
                got.router_addr   = o_router_addr;
                got.dns_addr      = o_dns_addr;
                got.subnet_mask   = o_subnet_mask;
                got.end_reason    = o_end_reason;
                if (expected_leases.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("unexpected result: %s", lease_text(got));
                    end
                end else begin
                    want = expected_leases.pop_front();
                    if (got.send_request !== want.send_request ||
                        got.got_address !== want.got_address ||
                        got.assigned_addr !== want.assigned_addr ||
                        got.router_addr !== want.router_addr ||
                        got.dns_addr !== want.dns_addr ||
                        got.subnet_mask !== want.subnet_mask ||
                        got.end_reason !== want.end_reason) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("expected %s", lease_text(want));
                            $display("actual   %s", lease_text(got));
                        end
                    end
                end
            end
            i_stall <= !calm_window() && ($urandom_range(99) < 12);
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] b,
                             input logic [31:0] addr);
        dop_pkg::t_item it;
        it.cmd          = cmd;
        it.data_byte    = b;
        it.offered_addr = addr;
        option_stream.push_back(it);
        if (cmd == dop_pkg::CMD_START) begin
            gen_open = 1'b1;
        end
        if (gen_open) begin
            fed_count = fed_count + 1;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(dop_pkg::CMD_BYTE, b, $urandom());
    endtask

    task automatic push_start(input logic [31:0] addr);
        push_item(dop_pkg::CMD_START, 8'($urandom_range(255)), addr);
    endtask

    task automatic push_end();
        push_byte(dop_pkg::OPT_END);
        gen_open = 1'b0;
    endtask

    task automatic push_option(input logic [7:0] code, input logic [7:0] len,
                               input logic [7:0] first);
        push_byte(code);
        push_byte(len);
        for (int i = 0; i < len; i++) begin
            push_byte(i == 0 ? first : 8'($urandom_range(255)));
        end
        if (code == dop_pkg::OPT_TYPE && len != 8'd0 && first == dop_pkg::TYPE_ACK) begin
            gen_open = 1'b0;
        end
    endtask

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r == 0) begin
            return 8'd255;
        end else if (r < 6) begin
            return 8'($urandom_range(7, 16));
        end
        return 8'($urandom_range(0, 6));
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stim_proc
        int nopt;
        int close_pick;
        logic [7:0] code;

        // Bytes before any start are dropped by the parser.
        push_byte(dop_pkg::OPT_END);
        push_start(32'hFFFF_FFFF);
        push_byte(dop_pkg::OPT_PAD);
        push_option(dop_pkg::OPT_ROUTER, 8'd5, 8'hFF);
        push_byte(dop_pkg::OPT_DNS);
        push_byte(8'd2);
        push_byte(8'h80);
        push_byte(8'h01);
        push_option(8'hC8, 8'd0, 8'h00);
        push_option(dop_pkg::OPT_TYPE, 8'd0, 8'h00);
        push_option(dop_pkg::OPT_TYPE, 8'd1, dop_pkg::TYPE_OFFER);
        push_end();
        push_byte(8'hAA);
        push_start(32'h0000_0000);
        push_option(dop_pkg::OPT_TYPE, 8'd1, dop_pkg::TYPE_ACK);

        while (fed_count < 600) begin
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(1, 12)) begin
                    push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              $urandom());
                end
            end else begin
                push_start(pick_addr());
                nopt = $urandom_range(0, 6);
                for (int k = 0; k < nopt && gen_open; k++) begin
                    case ($urandom_range(9))
                        0: push_byte(dop_pkg::OPT_PAD);
                        1: push_option(dop_pkg::OPT_ROUTER, pick_len(),
                                       8'($urandom_range(255)));
                        2: push_option(dop_pkg::OPT_DNS, pick_len(),
                                       8'($urandom_range(255)));
                        3: push_option(dop_pkg::OPT_MASK, pick_len(),
                                       8'($urandom_range(255)));
                        4: push_option(dop_pkg::OPT_TYPE, ($urandom_range(3) == 0) ?
                                       8'($urandom_range(0, 3)) : 8'd1,
                                       dop_pkg::TYPE_OFFER);
                        5: push_option(dop_pkg::OPT_TYPE, pick_len(),
                                       8'($urandom_range(255)));
                        6: begin
                            code = 8'($urandom_range(1, 254));
                            push_option(code, pick_len(), 8'($urandom_range(255)));
                        end
                        7: push_option(dop_pkg::OPT_TYPE, 8'd1, dop_pkg::TYPE_ACK);
                        default: push_option(dop_pkg::OPT_ROUTER, 8'd4,
                                             8'($urandom_range(255)));
                    endcase
                end
                if (gen_open) begin
                    close_pick = $urandom_range(9);
                    if (close_pick < 7) begin
                        push_end();
                    end else if (close_pick < 9) begin
                        push_option(dop_pkg::OPT_TYPE, 8'd1, dop_pkg::TYPE_ACK);
                    end
                end
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (option_stream.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_leases.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (expected_leases.size() != 0) begin
            mismatches = mismatches + expected_leases.size();
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
